FILE: rtl/jcs_pkg.sv
// ----------------------------------------------------------------------------
// JSONC comment stripper package
// Character codes and the types shared between the scanner and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package jcs_pkg;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;

  // One kept character together with its framing flags.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       text_end;
  } jcs_res_t;

  // What the scanner makes of the byte on its input this cycle.
  typedef struct packed {
    logic [1:0]      count;
    jcs_res_t [1:0]  res;
    logic            plain;
  } jcs_scan_t;

endpackage

`default_nettype wire

FILE: rtl/jcs_if.sv
// ----------------------------------------------------------------------------
// JSONC comment stripper channels
// Valid/ready channels for the input bytes and for the kept bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       text_end;

  modport source (output valid, output out_byte, output run_end, output text_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input text_end,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/jcs_scanner.sv
// ----------------------------------------------------------------------------
// JSONC comment stripper scanner
// Holds the scan mode and decides, per byte, which characters are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module jcs_scanner (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output jcs_pkg::jcs_scan_t      scan_o
);
  import jcs_pkg::*;

  typedef enum logic [2:0] {
    ModePlain  = 3'd0,
    ModeSlash  = 3'd1,
    ModeString = 3'd2,
    ModeEscape = 3'd3,
    ModeLine   = 3'd4,
    ModeBlock  = 3'd5,
    ModeBstar  = 3'd6
  } mode_e;

  mode_e     mode_q, mode_d;
  logic [1:0] count;
  jcs_res_t  res0, res1;

  always_comb begin
    mode_d = mode_q;
    count  = 2'd0;
    res0   = '{data: byte_i, run_end: 1'b0, text_end: 1'b0};
    res1   = '{data: byte_i, run_end: 1'b0, text_end: 1'b0};
    if (last_i) begin
      // The final byte is always kept; a held slash survives unless a comment opens.
      if (mode_q == ModeSlash && byte_i != ChStar && byte_i != ChSlash) begin
        res0.data     = ChSlash;
        res1.text_end = 1'b1;
        count         = 2'd2;
      end else begin
        res0.text_end = 1'b1;
        count         = 2'd1;
      end
      mode_d = ModePlain;
    end else begin
      case (mode_q)
        ModeSlash: begin
          if (byte_i == ChStar) begin
            mode_d = ModeBlock;
          end else if (byte_i == ChSlash) begin
            mode_d = ModeLine;
          end else begin
            res0.data = ChSlash;
            count     = 2'd2;
            mode_d    = (byte_i == ChQuote) ? ModeString : ModePlain;
          end
        end
        ModeString: begin
          count = 2'd1;
          if (byte_i == ChBackslash) begin
            mode_d = ModeEscape;
          end else if (byte_i == ChQuote) begin
            mode_d = ModePlain;
          end
        end
        ModeEscape: begin
          count  = 2'd1;
          mode_d = ModeString;
        end
        ModeLine: begin
          if (byte_i == ChNewline) begin
            count  = 2'd1;
            mode_d = ModePlain;
          end
        end
        ModeBlock: begin
          if (byte_i == ChStar) begin
            mode_d = ModeBstar;
          end
        end
        ModeBstar: begin
          if (byte_i == ChSlash) begin
            mode_d = ModePlain;
          end else if (byte_i != ChStar) begin
            mode_d = ModeBlock;
          end
        end
        default: begin
          if (byte_i == ChSlash) begin
            mode_d = ModeSlash;
          end else begin
            count  = 2'd1;
            mode_d = (byte_i == ChQuote) ? ModeString : ModePlain;
          end
        end
      endcase
    end
    if (count == 2'd2) begin
      res1.run_end = 1'b1;
    end else begin
      res0.run_end = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
    end else if (take_i) begin
      mode_q <= mode_d;
    end
  end

  assign scan_o = '{count: count, res: {res1, res0}, plain: (mode_q == ModePlain)};

endmodule

`default_nettype wire

FILE: rtl/jsonc_comment_stripper.sv
// ----------------------------------------------------------------------------
// JSONC comment stripper
// Removes line and block comments from a JSONC byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per request on in_i; the scan mode is updated in the
// same cycle and the kept characters (none, one or two) go into a
// two-entry result register that drives out_o. A byte that yields one or
// no character leaves room for the next, so text streams at one byte per
// cycle while the sink keeps up. A held slash that turns out not to open
// a comment yields two characters, and the input waits until the single
// output port has drained the first from the result register. run_end
// marks the last character a byte produced and text_end marks the byte
// that was flagged in_last; the next byte begins a new text in plain mode.
`default_nettype none

module jsonc_comment_stripper (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  jcs_in_if.sink     in_i,
  jcs_out_if.source  out_o
);
  import jcs_pkg::*;

  jcs_scan_t  scan;
  logic       take;
  logic       pop;
  logic [1:0] count_q, count_d;
  jcs_res_t   head_q, head_d;
  jcs_res_t   tail_q, tail_d;

  assign pop        = out_o.valid && out_o.ready;
  assign in_i.ready = (count_q == 2'd0) || (count_q == 2'd1 && out_o.ready);
  assign take       = in_i.valid && in_i.ready;

  jcs_scanner u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.in_byte),
    .last_i (in_i.in_last),
    .scan_o (scan)
  );

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (take) begin
      // The register is empty or empties this cycle, so the new characters replace it.
      count_d = scan.count;
      head_d  = scan.res[0];
      tail_d  = scan.res[1];
    end else if (pop) begin
      count_d = count_q - 2'd1;
      head_d  = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_o.valid    = (count_q != 2'd0);
  assign out_o.out_byte = head_q.data;
  assign out_o.run_end  = head_q.run_end;
  assign out_o.text_end = head_q.text_end;

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !in_i.ready)
    else $error("input taken while two characters wait");

  a_pair_head_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !head_q.run_end && tail_q.run_end)
    else $error("two-character run framed wrongly");

  a_text_end_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.text_end |-> out_o.run_end)
    else $error("text end not on the last character of its run");

  a_last_resets_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_i.in_last |=> scan.plain)
    else $error("scan mode not plain after the final byte");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSONC comment stripper testbench
// Feeds directed and random JSONC texts byte by byte through the stripper.
// Every kept character that comes out is checked against a scan-mode
// predictor that runs as each input request is taken. Both channels idle
// at random, the receiver once holds off long enough to back up the input,
// and the sender once waits for the output to drain.
// ----------------------------------------------------------------------------

module testbench;
  import jcs_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 120;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned TextBytes = 1000;
  localparam int unsigned MaxShown  = 10;
  localparam int unsigned SettleCyc = 20;

  typedef enum logic [2:0] {
    SCAN_PLAIN,
    SCAN_SLASH,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_BSTAR
  } scan_mode_e;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } text_req_t;

  logic clk;
  logic rst_n;

  jcs_in_if  in_ch ();
  jcs_out_if out_ch ();

  jsonc_comment_stripper uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  text_req_t   text_q[$];
  jcs_res_t    kept_q[$];
  scan_mode_e  scan_state = SCAN_PLAIN;
  int unsigned fault_cnt = 0;
  int unsigned accepted_bytes = 0;
  int unsigned counted_bytes = 0;
  int unsigned kept_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 0;
  bit          tx_calm = 0;
  bit          rx_calm = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Works out the characters one accepted byte yields and queues them.
  function automatic void strip_predict(logic [7:0] b, logic last);
    logic [7:0] kept[2];
    int         n;
    jcs_res_t   res;
    n = 0;
    if (last) begin
      if (scan_state == SCAN_SLASH && b != ChStar && b != ChSlash) begin
        kept[n] = ChSlash;
        n++;
      end
      kept[n] = b;
      n++;
      scan_state = SCAN_PLAIN;
    end else begin
      case (scan_state)
        SCAN_SLASH: begin
          if (b == ChStar) begin
            scan_state = SCAN_BLOCK;
          end else if (b == ChSlash) begin
            scan_state = SCAN_LINE;
          end else begin
            // The held slash opened nothing, so it goes out ahead of this byte.
            kept[n] = ChSlash;
            n++;
            kept[n] = b;
            n++;
            scan_state = (b == ChQuote) ? SCAN_STRING : SCAN_PLAIN;
          end
        end
        SCAN_STRING: begin
          kept[n] = b;
          n++;
          if (b == ChBackslash) begin
            scan_state = SCAN_ESCAPE;
          end else if (b == ChQuote) begin
            scan_state = SCAN_PLAIN;
          end
        end
        SCAN_ESCAPE: begin
          kept[n] = b;
          n++;
          scan_state = SCAN_STRING;
        end
        SCAN_LINE: begin
          if (b == ChNewline) begin
            kept[n] = b;
            n++;
            scan_state = SCAN_PLAIN;
          end
        end
        SCAN_BLOCK: begin
          if (b == ChStar) scan_state = SCAN_BSTAR;
        end
        SCAN_BSTAR: begin
          if (b == ChSlash) begin
            scan_state = SCAN_PLAIN;
          end else if (b != ChStar) begin
            scan_state = SCAN_BLOCK;
          end
        end
        default: begin
          if (b == ChSlash) begin
            scan_state = SCAN_SLASH;
          end else begin
            kept[n] = b;
            n++;
            scan_state = (b == ChQuote) ? SCAN_STRING : SCAN_PLAIN;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      res.data     = kept[i];
      res.run_end  = (i == n - 1);
      res.text_end = last && (i == n - 1);
      kept_q.push_back(res);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit counted);
    text_req_t req;
    req.data  = b;
    req.last  = 1'b0;
    req.gap   = tx_calm ? 0 : $urandom_range(0, 16);
    req.drain = 1'b0;
    text_q.push_back(req);
    if (counted) counted_bytes++;
  endtask

  task automatic add_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
    if (mark_last) text_q[$].last = 1'b1;
  endtask

  // One piece of a JSONC text.
  task automatic add_fragment();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(32, 126)), 1'b1);
      end
      3, 4: begin
        push_byte(ChQuote, 1'b1);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            push_byte(ChBackslash, 1'b1);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == ChQuote || b == ChBackslash) b = 8'h20;
            push_byte(b, 1'b1);
          end
        end
        push_byte(ChQuote, 1'b1);
      end
      5: begin
        push_byte(ChSlash, 1'b1);
        push_byte(ChSlash, 1'b1);
        repeat ($urandom_range(0, 10)) begin
          b = 8'($urandom_range(0, 255));
          if (b == ChNewline) b = ChStar;
          push_byte(b, 1'b1);
        end
        push_byte(ChNewline, 1'b1);
      end
      6, 7: begin
        push_byte(ChSlash, 1'b1);
        push_byte(ChStar, 1'b1);
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(0, 3))
            0: b = ChStar;
            1: b = ChSlash;
            default: b = 8'($urandom_range(0, 255));
          endcase
          push_byte(b, 1'b1);
        end
        if ($urandom_range(0, 1) == 0) push_byte(ChStar, 1'b1);
        push_byte(ChStar, 1'b1);
        push_byte(ChSlash, 1'b1);
      end
      8: begin
        push_byte(ChSlash, 1'b1);
        b = 8'($urandom_range(0, 255));
        if (b == ChStar || b == ChSlash) b = 8'h7B;
        push_byte(b, 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // Sender: takes the next request from text_q once the previous one has gone.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.in_last <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        strip_predict(in_ch.in_byte, in_ch.in_last);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() != 0 && !(text_q[0].drain && kept_q.size() != 0)) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= text_q[0].data;
          in_ch.in_last <= text_q[0].last;
          // Keep offering back to back while the receiver is held off.
          tx_gap        <= (hold_cnt != 0) ? 0 : text_q[0].gap;
          text_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off, counted here on its own.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted_bytes >= HoldAt) begin
      hold_cnt  <= LongHold;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks each kept character and draws a stall after it.
  always @(posedge clk or negedge rst_n) begin
    int unsigned stall;
    jcs_res_t    want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      stall = rx_stall;
      if (out_ch.valid && out_ch.ready) begin
        if (kept_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MaxShown) begin
            $display("%0t: unexpected character %02h run_end %0b text_end %0b", $time,
                     out_ch.out_byte, out_ch.run_end, out_ch.text_end);
          end
        end else begin
          want = kept_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.run_end !== want.run_end ||
              out_ch.text_end !== want.text_end) begin
            fault_cnt++;
            if (fault_cnt <= MaxShown) begin
              $display("%0t: character %0d expected %02h/%0b/%0b got %02h/%0b/%0b", $time,
                       kept_seen, want.data, want.run_end, want.text_end,
                       out_ch.out_byte, out_ch.run_end, out_ch.text_end);
            end
          end
        end
        kept_seen++;
        if (kept_seen % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall = rx_calm ? 0 : $urandom_range(0, 16);
      end else if (stall != 0) begin
        stall--;
      end
      rx_stall     <= stall;
      out_ch.ready <= (hold_cnt == 0) && (stall == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("%0t: no request moved for %0d cycles", $time, IdleLimit);
    $display("jsonc_comment_stripper regression: fail");
    $finish;
  end

  initial begin
    bit          drain_set;
    int unsigned total_bytes;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    drain_set     = 1'b0;

    // Directed texts: byte extremes, a quote after a held slash, an escaped
    // quote, both comment kinds, and the last byte in awkward modes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    add_text("/\"a\\\"\"", 1'b0);
    add_text("//\n", 1'b0);
    add_text("/**x*/", 1'b0);
    add_text("/*", 1'b1);
    add_text("/q", 1'b1);
    add_text("//x", 1'b1);
    add_text("\"\\z", 1'b1);

    // Random texts, each closed by a byte marked last.
    counted_bytes = 0;
    while (counted_bytes < TextBytes) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) add_fragment();
      if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
      text_q[$].last = 1'b1;
      // Once, the sender holds back until the output has fully drained.
      if (!drain_set && counted_bytes >= TextBytes / 2) begin
        text_q[$].drain = 1'b1;
        drain_set = 1'b1;
      end
    end
    total_bytes = text_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_bytes < total_bytes) @(posedge clk);
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("jsonc_comment_stripper regression: pass");
    end else begin
      $display("jsonc_comment_stripper regression: fail");
    end
    $finish;
  end

endmodule
